// ===== rtl/bhd_pkg.sv =====
package bhd_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam logic [4:0] NUM_VERTICES_RESET = 5'd16;
   localparam logic [3:0] HOP_COUNT_MAX = 4'd15;

   localparam logic CMD_ADD_EDGE = 1'b0;
   localparam logic CMD_QUERY    = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [3:0] from_vertex;
      logic [3:0] to_vertex;
   } req_item_type;

   typedef struct packed {
      logic       reachable;
      logic [3:0] hop_count;
      logic       bad_vertex;
   } rsp_item_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_query;
      logic add_edge;
      logic step;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
   } dp_status_type;

endpackage

// ===== rtl/bhd_ctrl.sv =====
module bhd_ctrl
   import bhd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_QUERY) begin
                  dp_cmd.load_query = 1'b1;
                  state_in          = ST_SEARCH;
               end else begin
                  dp_cmd.add_edge = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (status.done) begin
               // hold the finished search until the output register frees up
               if (out_free) begin
                  dp_cmd.emit = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               dp_cmd.step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = dp_cmd.emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== rtl/bhd_datapath.sv =====
module bhd_datapath
   import bhd_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_item,
   input  logic          csr_write_enable,
   input  logic [4:0]    csr_write_data,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type status,
   output rsp_item_type  rsp_item
);

   localparam int LW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (LW > 5) ? LW : 5;
   localparam int HW = (LW > 4) ? LW : 4;

   logic [MAX_VERTICES-1:0] adj_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] frontier_ff, frontier_in;
   logic [LW-1:0]           level_ff, level_in;
   logic [3:0]              dst_ff;
   logic                    bad_ff;
   logic [4:0]              num_vertices_ff;
   rsp_item_type            rsp_ff, rsp_in;

   logic [CW-1:0]           src_ext, dst_ext, nv_ext, dst_ff_ext;
   logic [MAX_VERTICES-1:0] src_bits, dst_bits, target_bits, live, expand;
   logic                    bad_req, dst_hit;
   logic [HW-1:0]           level_ext;

   assign src_ext    = CW'(req_item.from_vertex);
   assign dst_ext    = CW'(req_item.to_vertex);
   assign dst_ff_ext = CW'(dst_ff);
   assign nv_ext     = CW'(num_vertices_ff);

   assign bad_req = (src_ext >= nv_ext) || (dst_ext >= nv_ext) ||
                    (src_ext >= CW'(MAX_VERTICES)) || (dst_ext >= CW'(MAX_VERTICES));

   always_comb begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
         src_bits[v]    = (src_ext == CW'(v));
         dst_bits[v]    = (dst_ext == CW'(v));
         target_bits[v] = (dst_ff_ext == CW'(v));
         live[v]        = (nv_ext > CW'(v));
      end
   end

   // union of the rows of every frontier vertex, limited to live vertices not yet visited
   always_comb begin
      expand = '0;
      for (int v = 0; v < MAX_VERTICES; v++) begin
         if (frontier_ff[v]) expand = expand | adj_ff[v];
      end
      expand = expand & live & ~visited_ff;
   end

   assign dst_hit     = |(visited_ff & target_bits);
   assign status.done = bad_ff || dst_hit || (frontier_ff == '0);

   always_comb begin
      visited_in  = visited_ff;
      frontier_in = frontier_ff;
      level_in    = level_ff;
      if (dp_cmd.load_query) begin
         visited_in  = src_bits;
         frontier_in = src_bits;
         level_in    = '0;
      end else if (dp_cmd.step) begin
         visited_in  = visited_ff | expand;
         frontier_in = expand;
         level_in    = level_ff + LW'(1);
      end
   end

   assign level_ext = HW'(level_ff);

   always_comb begin
      rsp_in            = rsp_ff;
      if (dp_cmd.emit) begin
         rsp_in.bad_vertex = bad_ff;
         rsp_in.reachable  = !bad_ff && dst_hit;
         rsp_in.hop_count  = '0;
         if (!bad_ff && dst_hit) begin
            rsp_in.hop_count = (level_ext > HW'(HOP_COUNT_MAX)) ?
                               HOP_COUNT_MAX : level_ext[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < MAX_VERTICES; v++) adj_ff[v] <= '0;
         num_vertices_ff <= NUM_VERTICES_RESET;
      end else begin
         if (csr_write_enable) num_vertices_ff <= csr_write_data;
         // drop edges with an out-of-range vertex
         if (dp_cmd.add_edge && !bad_req) begin
            for (int v = 0; v < MAX_VERTICES; v++) begin
               if (src_bits[v]) adj_ff[v] <= adj_ff[v] | dst_bits;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      visited_ff  <= visited_in;
      frontier_ff <= frontier_in;
      level_ff    <= level_in;
      rsp_ff      <= rsp_in;
      if (dp_cmd.load_query) begin
         dst_ff <= req_item.to_vertex;
         bad_ff <= bad_req;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== rtl/bfs_hop_distance.sv =====
// Add-edge item: accepted while idle, no result.
// Query item: accepted while idle; L frontier levels are expanded (at most MAX_VERTICES), then the result
// is registered once the output register is free; the search loop expands one level per cycle.
// Throughput: one item at a time; a new item is taken once the search has handed off.
// Reset (synchronous): clears the adjacency matrix, sets num_vertices to 16, idles.
module bfs_hop_distance
   import bhd_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_write_enable,
   input  logic [4:0]   csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   bhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_item.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   bhd_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .dp_cmd           (dp_cmd),
      .status           (status),
      .rsp_item         (rsp_item)
   );

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.emit && rsp_valid && !rsp_ready))
      else $error("result overwritten while stalled");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load_query, dp_cmd.add_edge, dp_cmd.step, dp_cmd.emit}))
      else $error("more than one datapath command");

   a_bad_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.bad_vertex) |-> (!rsp_item.reachable && rsp_item.hop_count == '0))
      else $error("bad vertex result carries a distance");

   a_emit_after_search: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> status.done)
      else $error("result emitted before search finished");

endmodule
